FILE: sv/psds_pkg.sv
// Package: sizes, codes and item types of the pending slot discovery scheduler.
`default_nettype none

package psds_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int WORD_BITS  = 32;
  localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int WA_W       = $clog2(WORD_COUNT);
  localparam int WB_W       = $clog2(WORD_BITS);
  localparam int CHOSEN_W   = 10;

  typedef enum logic [1:0] {
    CMD_REPORT = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_INJECT = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_RECORDED = 3'd0,
    ST_REJECTED = 3'd1,
    ST_IDLE     = 3'd2,
    ST_PROBE    = 3'd3,
    ST_ONLINE   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    NODE_UNKNOWN = 2'd0,
    NODE_PROBING = 2'd1,
    NODE_ACTIVE  = 2'd2
  } node_state_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RPT,
    S_SCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] slot;
    logic        key_present;
    logic [31:0] identity_key;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [CHOSEN_W-1:0] chosen_slot;
    logic [1:0]          new_node_state;
    logic                event_valid;
    logic [31:0]         event_key;
  } out_item_t;

endpackage

`default_nettype wire

FILE: sv/pending_slot_discovery_scheduler.sv
// Top level: pending bitmap, node state table and the sequencer that serves them.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------
//  in      | in  | in_valid_i/in_ready_o  | in_item_i  (cmd, slot, key)
//  out     | out | out_valid_o/out_ready_i| out_item_o (status, slot, event)
//
// Report: read the bitmap word on accept, write it back in S_RPT, then S_RESP
// loads the output register. Inject and reject go straight to S_RESP. Tick:
// one bitmap word per cycle through the single read port of the bitmap memory,
// lowest word first. After reset a clearing pass over all SLOT_COUNT (1024)
// entries zeroes the node table; no item is taken meanwhile. A stalled output
// holds the result; the next item is accepted while it waits.
`default_nettype none

module pending_slot_discovery_scheduler (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire psds_pkg::in_item_t   in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output psds_pkg::out_item_t       out_item_o
);
  import psds_pkg::*;

  state_e state_q, state_d;

  // bitmap memory, one valid bit per word stands in for the reset value
  logic [WORD_BITS-1:0]  pend_mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] word_vld_q, word_vld_d;
  logic [WORD_BITS-1:0]  rd_word_q;
  logic                  rd_vld_q;
  logic [WA_W-1:0]       rd_addr, chk_addr_q;
  logic                  pend_we;
  logic [WA_W-1:0]       pend_waddr;
  logic [WORD_BITS-1:0]  pend_wdata;
  logic [WORD_BITS-1:0]  word;

  // node state memory, cleared by a sweep after reset
  logic [1:0]            node_mem [SLOT_COUNT];
  logic [1:0]            node_rd_q;
  logic [SLOT_W-1:0]     node_rd_addr;
  logic                  node_we;
  logic [SLOT_W-1:0]     node_waddr;
  logic [1:0]            node_wdata;

  logic [SLOT_W-1:0]     clr_cnt_q, clr_cnt_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  out_item_t             res_q, res_d;
  out_item_t             out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic                  accept;
  logic                  in_range;
  logic [WB_W-1:0]       pos;

  assign word     = rd_vld_q ? rd_word_q : '0;
  assign accept   = in_valid_i && in_ready_o;
  assign in_range = {1'b0, in_item_i.slot} < 17'(SLOT_COUNT);

  // lowest set bit of the word under check
  always_comb begin
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (word[b]) pos = WB_W'(b);
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    rd_addr      = chk_addr_q + WA_W'(1);
    node_rd_addr = in_item_i.slot[SLOT_W-1:0];
    pend_we      = 1'b0;
    pend_waddr   = chk_addr_q;
    pend_wdata   = word;
    word_vld_d   = word_vld_q;
    node_we      = 1'b0;
    node_waddr   = clr_cnt_q;
    node_wdata   = NODE_UNKNOWN;
    clr_cnt_d    = clr_cnt_q;
    slot_d       = slot_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_CLEAR: begin
        node_we   = 1'b1;
        clr_cnt_d = clr_cnt_q + SLOT_W'(1);
        if (clr_cnt_q == SLOT_W'(SLOT_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        rd_addr    = (in_item_i.cmd == CMD_TICK) ? '0 :
                     in_item_i.slot[SLOT_W-1:WB_W];
        if (accept) begin
          slot_d = in_item_i.slot[SLOT_W-1:0];
          res_d  = '0;
          priority if (in_item_i.cmd == CMD_REPORT && in_range) begin
            state_d = S_RPT;
          end else if (in_item_i.cmd == CMD_TICK) begin
            state_d = S_SCAN;
          end else if (in_item_i.cmd == CMD_INJECT && in_range &&
                       in_item_i.key_present) begin
            node_we              = 1'b1;
            node_waddr           = in_item_i.slot[SLOT_W-1:0];
            node_wdata           = NODE_ACTIVE;
            res_d.status         = ST_ONLINE;
            res_d.chosen_slot    = in_item_i.slot[CHOSEN_W-1:0];
            res_d.new_node_state = NODE_ACTIVE;
            res_d.event_valid    = 1'b1;
            res_d.event_key      = in_item_i.identity_key;
            state_d              = S_RESP;
          end else begin
            res_d.status = ST_REJECTED;
            state_d      = S_RESP;
          end
        end
      end
      S_RPT: begin
        // chk_addr_q holds the address of the word read on accept
        pend_we                  = 1'b1;
        pend_wdata               = word | (WORD_BITS'(1) << slot_q[WB_W-1:0]);
        word_vld_d[chk_addr_q]   = 1'b1;
        res_d.status             = ST_RECORDED;
        res_d.chosen_slot        = CHOSEN_W'(slot_q);
        res_d.new_node_state     = node_rd_q;
        state_d                  = S_RESP;
      end
      S_SCAN: begin
        if (word != '0) begin
          pend_we                = 1'b1;
          pend_wdata             = word & ~(WORD_BITS'(1) << pos);
          word_vld_d[chk_addr_q] = 1'b1;
          node_we                = 1'b1;
          node_waddr             = SLOT_W'({chk_addr_q, pos});
          node_wdata             = NODE_PROBING;
          res_d.status           = ST_PROBE;
          res_d.chosen_slot      = CHOSEN_W'({chk_addr_q, pos});
          res_d.new_node_state   = NODE_PROBING;
          state_d                = S_RESP;
        end else if (chk_addr_q == WA_W'(WORD_COUNT - 1)) begin
          res_d.status = ST_IDLE;
          state_d      = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      word_vld_q  <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      word_vld_q  <= word_vld_d;
      rd_vld_q    <= word_vld_q[rd_addr];
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_addr_q <= rd_addr;
    slot_q     <= slot_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
    rd_word_q <= pend_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rd_q <= node_mem[node_rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("accepted item did not make the block busy");

  a_event_online: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.event_valid == (out_item_o.status == ST_ONLINE)))
    else $error("event flag disagrees with status");

  a_probe_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_PROBE) |->
      out_item_o.new_node_state == NODE_PROBING)
    else $error("probe result without probing state");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status == ST_REJECTED || out_item_o.status == ST_IDLE))
      |-> (out_item_o.chosen_slot == '0 && out_item_o.event_key == '0 &&
           out_item_o.new_node_state == NODE_UNKNOWN))
    else $error("empty result carries payload");

  a_pend_write_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_we |=> word_vld_q[$past(pend_waddr)])
    else $error("bitmap word written without valid bit");

endmodule

`default_nettype wire

FILE: tb/tb_pending_slot_discovery_scheduler.sv
// Testbench: directed table and random traffic for the pending slot discovery scheduler.
module tb_pending_slot_discovery_scheduler;
  import psds_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 5;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_LEN     = 300;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 96;
  localparam int MAX_REPORTS  = 40;
  localparam int NDIR         = 25;

  // cmd encoding the block does not define; must be rejected
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum int {
    TRAFFIC_MIXED,
    TRAFFIC_FILL,
    TRAFFIC_DRAIN
  } traffic_e;

  // cumulative percentages per traffic mode: reports below REPORT_PCT, ticks below TICK_PCT
  localparam int REPORT_PCT [3] = '{45, 75, 15};
  localparam int TICK_PCT   [3] = '{80, 90, 85};

  typedef struct packed {
    in_item_t  item;
    logic      known;
    out_item_t result;
  } dir_row_t;

  localparam out_item_t RES_NONE   = '0;
  localparam out_item_t RES_REJECT = '{ST_REJECTED, 10'd0, NODE_UNKNOWN, 1'b0, 32'd0};
  localparam out_item_t RES_EMPTY  = '{ST_IDLE, 10'd0, NODE_UNKNOWN, 1'b0, 32'd0};

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  bit [WORD_BITS-1:0] pend_words [WORD_COUNT];
  node_state_e        node_tbl [SLOT_COUNT];
  out_item_t          awaited_q [$];
  int                 errors = 0;
  int                 results_seen = 0;
  bit                 calm = 1'b0;

  dir_row_t dir_tbl [0:NDIR-1] = '{
    '{'{CMD_TICK, 16'd0, 1'b0, 32'd0}, 1'b1, RES_EMPTY},
    '{'{CMD_REPORT, 16'd0, 1'b0, 32'd0}, 1'b1,
      '{ST_RECORDED, 10'd0, NODE_UNKNOWN, 1'b0, 32'd0}},
    '{'{CMD_REPORT, 16'd1023, 1'b1, 32'hFFFF_FFFF}, 1'b1,
      '{ST_RECORDED, 10'd1023, NODE_UNKNOWN, 1'b0, 32'd0}},
    '{'{CMD_REPORT, 16'd0, 1'b0, 32'd0}, 1'b0, RES_NONE},
    '{'{CMD_REPORT, 16'd1024, 1'b0, 32'd0}, 1'b1, RES_REJECT},
    '{'{CMD_REPORT, 16'hFFFF, 1'b1, 32'hFFFF_FFFF}, 1'b1, RES_REJECT},
    '{'{CMD_TICK, 16'hFFFF, 1'b1, 32'hFFFF_FFFF}, 1'b1,
      '{ST_PROBE, 10'd0, NODE_PROBING, 1'b0, 32'd0}},
    '{'{CMD_TICK, 16'd0, 1'b0, 32'd0}, 1'b1,
      '{ST_PROBE, 10'd1023, NODE_PROBING, 1'b0, 32'd0}},
    '{'{CMD_TICK, 16'd0, 1'b0, 32'd0}, 1'b1, RES_EMPTY},
    '{'{CMD_INJECT, 16'd1023, 1'b1, 32'hFFFF_FFFF}, 1'b1,
      '{ST_ONLINE, 10'd1023, NODE_ACTIVE, 1'b1, 32'hFFFF_FFFF}},
    '{'{CMD_INJECT, 16'd0, 1'b1, 32'd0}, 1'b1,
      '{ST_ONLINE, 10'd0, NODE_ACTIVE, 1'b1, 32'd0}},
    '{'{CMD_INJECT, 16'd5, 1'b0, 32'hA5A5_A5A5}, 1'b1, RES_REJECT},
    '{'{CMD_INJECT, 16'd1024, 1'b1, 32'h0000_1234}, 1'b1, RES_REJECT},
    '{'{CMD_UNUSED, 16'd7, 1'b1, 32'h0000_0055}, 1'b1, RES_REJECT},
    '{'{CMD_REPORT, 16'd1023, 1'b0, 32'd0}, 1'b0, RES_NONE},
    '{'{CMD_REPORT, 16'd31, 1'b0, 32'd0}, 1'b0, RES_NONE},
    '{'{CMD_REPORT, 16'd32, 1'b0, 32'd0}, 1'b0, RES_NONE},
    '{'{CMD_REPORT, 16'd992, 1'b0, 32'd0}, 1'b0, RES_NONE},
    '{'{CMD_REPORT, 16'd512, 1'b0, 32'd0}, 1'b0, RES_NONE},
    '{'{CMD_TICK, 16'd0, 1'b0, 32'd0}, 1'b0, RES_NONE},
    '{'{CMD_TICK, 16'd0, 1'b0, 32'd0}, 1'b0, RES_NONE},
    '{'{CMD_TICK, 16'd0, 1'b0, 32'd0}, 1'b0, RES_NONE},
    '{'{CMD_TICK, 16'd0, 1'b0, 32'd0}, 1'b0, RES_NONE},
    '{'{CMD_TICK, 16'd0, 1'b0, 32'd0}, 1'b0, RES_NONE},
    '{'{CMD_TICK, 16'd0, 1'b0, 32'd0}, 1'b0, RES_NONE}
  };

  pending_slot_discovery_scheduler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Applies one item to the bitmap and node table and returns what the block must answer.
  function automatic out_item_t discovery_step(input in_item_t it);
    out_item_t r;
    int        w;
    int        b;
    int        s;
    bit        found;
    r = RES_REJECT;
    found = 1'b0;
    case (it.cmd)
      CMD_REPORT: begin
        if (it.slot < SLOT_COUNT) begin
          pend_words[it.slot / WORD_BITS][it.slot % WORD_BITS] = 1'b1;
          r.status         = ST_RECORDED;
          r.chosen_slot    = it.slot[CHOSEN_W-1:0];
          r.new_node_state = node_tbl[it.slot];
        end
      end
      CMD_TICK: begin
        r = RES_EMPTY;
        for (w = 0; w < WORD_COUNT; w++) begin
          if (!found && pend_words[w] != '0) begin
            for (b = 0; b < WORD_BITS; b++) begin
              if (!found && pend_words[w][b]) begin
                found = 1'b1;
                pend_words[w][b] = 1'b0;
                s = w * WORD_BITS + b;
                node_tbl[s] = NODE_PROBING;
                r.status         = ST_PROBE;
                r.chosen_slot    = s[CHOSEN_W-1:0];
                r.new_node_state = NODE_PROBING;
              end
            end
          end
        end
      end
      CMD_INJECT: begin
        if (it.slot < SLOT_COUNT && it.key_present) begin
          node_tbl[it.slot] = NODE_ACTIVE;
          r.status         = ST_ONLINE;
          r.chosen_slot    = it.slot[CHOSEN_W-1:0];
          r.new_node_state = NODE_ACTIVE;
          r.event_valid    = 1'b1;
          r.event_key      = it.identity_key;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // mostly no gap, some short ones, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_slot(input int win_base);
    if ($urandom_range(0, 9) < 3) return 16'(win_base + $urandom_range(0, 15));
    return 16'($urandom_range(0, SLOT_COUNT - 1));
  endfunction

  function automatic in_item_t rand_item(input traffic_e mode, input int win_base);
    in_item_t it;
    int       r;
    it.cmd          = CMD_REPORT;
    it.slot         = 16'($urandom);
    it.key_present  = 1'($urandom);
    it.identity_key = $urandom;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // malformed traffic
      case ($urandom_range(0, 3))
        0: it.slot = 16'($urandom_range(SLOT_COUNT, 65535));
        1: begin
          it.cmd         = CMD_INJECT;
          it.slot        = pick_slot(win_base);
          it.key_present = 1'b0;
        end
        2: begin
          it.cmd         = CMD_INJECT;
          it.slot        = 16'($urandom_range(SLOT_COUNT, 65535));
          it.key_present = 1'b1;
        end
        default: it.cmd = CMD_UNUSED;
      endcase
      return it;
    end
    r = $urandom_range(0, 99);
    if (r < REPORT_PCT[mode]) begin
      it.slot = pick_slot(win_base);
    end else if (r < TICK_PCT[mode]) begin
      it.cmd = CMD_TICK;
    end else begin
      it.cmd         = CMD_INJECT;
      it.slot        = pick_slot(win_base);
      it.key_present = 1'b1;
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input in_item_t it, input logic known, input out_item_t given);
    int        gap;
    out_item_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = discovery_step(it);
    awaited_q.push_back(known ? given : pred);
    @(negedge clk_i);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (awaited_q.size() == 0) begin
        $display("%0t: result %h arrived with nothing expected", $time, out_item_o);
        errors++;
      end else begin
        want = awaited_q.pop_front();
        cmp_field("status", 32'(want.status), 32'(out_item_o.status));
        cmp_field("chosen_slot", 32'(want.chosen_slot), 32'(out_item_o.chosen_slot));
        cmp_field("new_node_state", 32'(want.new_node_state),
                  32'(out_item_o.new_node_state));
        cmp_field("event_valid", 32'(want.event_valid), 32'(out_item_o.event_valid));
        cmp_field("event_key", want.event_key, out_item_o.event_key);
      end
    end
  end

  // Output side: random stalls plus one long hold-off so the block backs up.
  initial begin : receiver
    int stall_left;
    int held;
    bit hold_done;
    stall_left  = 0;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        for (held = 0; held < HOLD_LEN; held++) @(negedge clk_i);
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int        i;
    int        ph;
    int        win_base;
    traffic_e  mode;
    in_item_t  it;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    for (i = 0; i < SLOT_COUNT; i++) node_tbl[i] = NODE_UNKNOWN;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < NDIR; i++)
      send_item(dir_tbl[i].item, dir_tbl[i].known, dir_tbl[i].result);

    for (ph = 0; ph < PHASES; ph++) begin
      mode     = traffic_e'($urandom_range(0, 2));
      calm     = ($urandom_range(0, 3) == 0);
      win_base = $urandom_range(0, SLOT_COUNT - 16);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        it = rand_item(mode, win_base);
        send_item(it, 1'b0, RES_NONE);
      end
    end
    in_valid_i <= 1'b0;

    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("%0t: timeout", $time);
    $display("Mismatches found");
    $finish;
  end

endmodule
